// ----- sv/swhc_pkg.sv -----
// Shared types and constants for the sliding window hit counter.
`timescale 1ns / 1ps

package swhc_pkg;

  localparam int BUCKETS_DEF = 512;
  localparam int TS_W = 32;
  localparam int HITS_W = 32;
  localparam int WIN_W = 10;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(300);

  localparam logic KIND_HIT = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [WIN_W-1:0] cfg_data_t;

  typedef struct packed {
    logic            kind;
    logic [TS_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [HITS_W-1:0] window_hits;
    logic              out_of_order;
  } out_item_t;

endpackage

// ----- sv/swhc_chan_if.sv -----
// Valid/ready channel interface with a typed payload.
`timescale 1ns / 1ps

interface swhc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/swhc_mod.sv -----
// Timestamp remainder by the bucket count, by reciprocal multiplication and correction.
`timescale 1ns / 1ps

module swhc_mod
  import swhc_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int IDX_W = $clog2(BUCKETS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [TS_W-1:0]  dividend,
  output logic             done,
  output logic [IDX_W-1:0] rem
);

  // floor(t * RECIP / 2**SHIFT) is the quotient or one below it
  localparam int SHIFT = TS_W + IDX_W - 1;
  localparam logic [TS_W-1:0] RECIP = TS_W'((64'd1 << SHIFT) / 64'(BUCKETS));
  localparam logic [TS_W-1:0] DIVISOR = TS_W'(BUCKETS);

  logic              mul_vld_r;
  logic              sub_vld_r;
  logic              done_r;
  logic [TS_W-1:0]   t_r;
  logic [2*TS_W-1:0] prod_r;
  logic [TS_W-1:0]   qb_r;
  logic [IDX_W-1:0]  rem_r;
  logic [TS_W-1:0]   quot;
  logic [TS_W-1:0]   rem_wide;
  logic [IDX_W-1:0]  rem_nxt;

  assign quot     = TS_W'(prod_r >> SHIFT);
  assign rem_wide = t_r - qb_r;

  always_comb begin
    if (rem_wide >= DIVISOR) begin
      rem_nxt = IDX_W'(rem_wide - DIVISOR);
    end else begin
      rem_nxt = IDX_W'(rem_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      sub_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      mul_vld_r <= start;
      sub_vld_r <= mul_vld_r;
      done_r    <= sub_vld_r;
      if (start) begin
        t_r    <= dividend;
        prod_r <= (2*TS_W)'(dividend) * (2*TS_W)'(RECIP);
      end
      if (mul_vld_r) begin
        qb_r <= quot * DIVISOR;
      end
      if (sub_vld_r) begin
        rem_r <= rem_nxt;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- sv/swhc_mem.sv -----
// Bucket memory: one write port, one registered read port.
`timescale 1ns / 1ps

module swhc_mem #(
  parameter int DEPTH = 512,
  parameter int AW = $clog2(DEPTH),
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/sliding_window_hit_counter.sv -----
// Top level: sliding window hit counter with a ring of per-second buckets.
//
//   channel  | dir | payload                        | transaction
//   ---------+-----+--------------------------------+-------------------------
//   in_ch    | in  | kind, timestamp                | one hit or query
//   out_ch   | out | window_hits, out_of_order      | one query or reject result
//   cfg_ch   | in  | window_seconds (10 bits)       | window length write
//
// After reset every bucket of the memory is swept to zero; in_ch.ready stays
// low meanwhile. A hit goes through the remainder unit, then a read and a
// write of its bucket. A query goes through the remainder unit, then n =
// min(w, t + 1) bucket reads, w the effective window, one per cycle on the
// memory port. An out-of-order item skips the remainder unit. A stalled
// result blocks the next result, not the next input; cfg_ch is always ready.
`timescale 1ns / 1ps

module sliding_window_hit_counter
  import swhc_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  swhc_chan_if.sink   in_ch,
  swhc_chan_if.source out_ch,
  swhc_chan_if.sink   cfg_ch
);

  localparam int IDX_W = $clog2(BUCKETS);
  localparam int ENT_W = TS_W + HITS_W;
  localparam int WIN_CAP = (BUCKETS < (2**WIN_W - 1)) ? BUCKETS : (2**WIN_W - 1);
  localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(WIN_CAP);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUCKETS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD, S_HIT_RD, S_HIT_WR, S_SUM, S_DRAIN, S_RESULT
  } state_t;

  state_t            state_r;
  logic [WIN_W-1:0]  win_r;
  logic [TS_W-1:0]   last_time_r;
  logic [TS_W-1:0]   t_r;
  logic              kind_r;
  logic              ooo_r;
  logic [IDX_W-1:0]  clr_idx_r;
  logic [IDX_W-1:0]  idx_r;
  logic [TS_W-1:0]   exp_r;
  logic [WIN_W-1:0]  cnt_r;
  logic              pend_r;
  logic [TS_W-1:0]   pend_exp_r;
  logic [HITS_W-1:0] acc_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_acc;
  logic              in_ooo;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_rem;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic [ENT_W-1:0]  mem_wr_data;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [ENT_W-1:0]  mem_rd_data;
  logic [TS_W-1:0]   rd_tag;
  logic [HITS_W-1:0] rd_hits;
  logic [HITS_W-1:0] hit_inc;
  logic [HITS_W:0]   acc_sum;
  logic [WIN_W-1:0]  eff_win;
  logic              out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ooo = in_ch.data.timestamp < last_time_r;
  assign out_free = !out_valid_r || out_ch.ready;

  assign rd_tag  = mem_rd_data[ENT_W-1:HITS_W];
  assign rd_hits = mem_rd_data[HITS_W-1:0];
  assign hit_inc = (rd_hits == '1) ? rd_hits : rd_hits + 1'b1;
  assign acc_sum = {1'b0, acc_r} + {1'b0, rd_hits};

  always_comb begin
    eff_win = win_r;
    if (win_r == '0) begin
      eff_win = WIN_W'(1);
    end else if (win_r > WIN_MAX) begin
      eff_win = WIN_MAX;
    end
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_idx_r;
      end
      S_HIT_RD: mem_rd_en = 1'b1;
      S_HIT_WR: begin
        mem_wr_en = 1'b1;
        if (rd_tag == t_r) begin
          mem_wr_data = {t_r, hit_inc};
        end else begin
          mem_wr_data = {t_r, HITS_W'(1)};
        end
      end
      S_SUM: mem_rd_en = 1'b1;
      default: ;
    endcase
  end
  assign mem_rd_addr = idx_r;

  swhc_mod #(
    .BUCKETS(BUCKETS),
    .IDX_W  (IDX_W)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc && !in_ooo),
    .dividend(in_ch.data.timestamp),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  swhc_mem #(
    .DEPTH(BUCKETS),
    .AW   (IDX_W),
    .DW   (ENT_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      win_r       <= WIN_RESET;
      last_time_r <= '0;
      clr_idx_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        win_r <= cfg_ch.data;
      end
      if (state_r == S_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (pend_r) begin
        if (rd_tag == pend_exp_r) begin
          acc_r <= acc_sum[HITS_W] ? '1 : acc_sum[HITS_W-1:0];
        end
      end
      pend_r <= (state_r == S_SUM);
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == IDX_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            kind_r <= in_ch.data.kind;
            t_r    <= in_ch.data.timestamp;
            ooo_r  <= in_ooo;
            if (in_ooo) begin
              state_r <= S_RESULT;
            end else begin
              last_time_r <= in_ch.data.timestamp;
              state_r     <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            idx_r <= mod_rem;
            exp_r <= t_r;
            cnt_r <= eff_win;
            acc_r <= '0;
            state_r <= (kind_r == KIND_HIT) ? S_HIT_RD : S_SUM;
          end
        end
        S_HIT_RD: state_r <= S_HIT_WR;
        S_HIT_WR: state_r <= S_IDLE;
        S_SUM: begin
          pend_exp_r <= exp_r;
          if (cnt_r == WIN_W'(1) || exp_r == '0) begin
            state_r <= S_DRAIN;
          end else begin
            cnt_r <= cnt_r - 1'b1;
            exp_r <= exp_r - 1'b1;
            idx_r <= (idx_r == '0) ? IDX_LAST : idx_r - 1'b1;
          end
        end
        S_DRAIN: state_r <= S_RESULT;
        S_RESULT: begin
          if (out_free) begin
            out_data_r.out_of_order <= ooo_r;
            out_data_r.window_hits  <= ooo_r ? '0 : acc_r;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_ooo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.out_of_order |-> out_ch.data.window_hits == '0)
    else $error("out-of-order result with nonzero hits");

  a_ooo_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ooo |=> $stable(last_time_r))
    else $error("rejected item changed last time");

  a_sum_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM |-> cnt_r != '0 && cnt_r <= WIN_MAX)
    else $error("window counter out of range");

  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_MOD)
    else $error("remainder done outside its wait state");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESULT && out_free |=> state_r == S_IDLE && out_valid_r)
    else $error("result not loaded");

endmodule

// ----- sim/tb_sliding_window_hit_counter.sv -----
// Testbench for the sliding window hit counter: random hits and queries vs. a bucket ring.
`timescale 1ns / 1ps

module tb_sliding_window_hit_counter;
  import swhc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [TS_W-1:0] TS_MAX = '1;
  localparam logic [TS_W-1:0] TS_CAP = 32'hE000_0000;

  class hit_window_model;
    logic [TS_W-1:0]   tag_mem[BUCKETS_DEF];
    logic [HITS_W-1:0] hit_mem[BUCKETS_DEF];
    logic [TS_W-1:0]   last_ts;
    cfg_data_t         window_reg;
    out_item_t         pending_counts[$];
    int                errors;

    function new();
      foreach (tag_mem[i]) begin
        tag_mem[i] = '0;
        hit_mem[i] = '0;
      end
      last_ts = '0;
      window_reg = WIN_RESET;
      errors = 0;
    endfunction

    function void set_window(cfg_data_t v);
      window_reg = v;
    endfunction

    function void accept_item(in_item_t it);
      out_item_t       res;
      int unsigned     idx;
      int unsigned     w;
      longint unsigned sum;
      if (it.timestamp < last_ts) begin
        res.window_hits = '0;
        res.out_of_order = 1'b1;
        pending_counts.push_back(res);
        return;
      end
      last_ts = it.timestamp;
      if (it.kind == KIND_HIT) begin
        idx = it.timestamp % BUCKETS_DEF;
        if (tag_mem[idx] == it.timestamp) begin
          if (hit_mem[idx] != '1) hit_mem[idx] = hit_mem[idx] + 1'b1;
        end else begin
          tag_mem[idx] = it.timestamp;
          hit_mem[idx] = HITS_W'(1);
        end
        return;
      end
      w = 32'(window_reg);
      if (w == 0) w = 1;
      if (w > BUCKETS_DEF) w = BUCKETS_DEF;
      sum = 0;
      foreach (tag_mem[i]) begin
        if (tag_mem[i] <= it.timestamp && (it.timestamp - tag_mem[i]) < w) begin
          sum += 64'(hit_mem[i]);
        end
      end
      if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
      res.window_hits = sum[HITS_W-1:0];
      res.out_of_order = 1'b0;
      pending_counts.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hits %0d ooo %0b",
                 $time, got.window_hits, got.out_of_order);
        errors++;
        return;
      end
      want = pending_counts.pop_front();
      if (got.window_hits !== want.window_hits) begin
        $display("%0t: window_hits mismatch, expected %0d actual %0d",
                 $time, want.window_hits, got.window_hits);
        errors++;
      end
      if (got.out_of_order !== want.out_of_order) begin
        $display("%0t: out_of_order mismatch, expected %0b actual %0b",
                 $time, want.out_of_order, got.out_of_order);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  swhc_chan_if #(.payload_t(in_item_t))  in_ch ();
  swhc_chan_if #(.payload_t(out_item_t)) out_ch ();
  swhc_chan_if #(.payload_t(cfg_data_t)) cfg_ch ();

  hit_window_model sb = new();

  logic [TS_W-1:0] stim_ts;
  bit              quiet_run;
  int              idle_cycles;

  sliding_window_hit_counter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait();
    return quiet_run ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic push_item(input logic kind, input logic [TS_W-1:0] ts);
    int       gap;
    in_item_t it;
    gap = draw_wait();
    it.kind = kind;
    it.timestamp = ts;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = it;
    do @(posedge clk); while (!in_ch.ready);
    sb.accept_item(it);
    if ($urandom_range(0, 29) == 0) quiet_run = !quiet_run;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input cfg_data_t v);
    drain_results();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_window(v);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_random(input int n, input logic [TS_W-1:0] cap);
    int              r;
    longint unsigned nxt;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8 && stim_ts >= 2) begin
        push_item(1'($urandom_range(0, 1)), $urandom_range(1, stim_ts - 1));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) nxt = stim_ts;
        else if (r < 80) nxt = stim_ts + $urandom_range(1, 3);
        else if (r < 95) nxt = stim_ts + $urandom_range(0, 700);
        else nxt = stim_ts + $urandom_range(0, 1 << 26);
        if (nxt > cap) nxt = cap;
        stim_ts = nxt[TS_W-1:0];
        push_item(($urandom_range(0, 99) < 62) ? KIND_HIT : KIND_QUERY, stim_ts);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sliding_window_hit_counter failed");
      $finish;
    end
  end

  // result sink with random stalls
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = draw_wait();
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    cfg_data_t windows[8];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    idle_cycles = 0;
    quiet_run = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset window of 300
    push_item(KIND_QUERY, 1);
    push_item(KIND_HIT, 1);
    push_item(KIND_HIT, 1);
    push_item(KIND_HIT, 2);
    push_item(KIND_QUERY, 2);
    push_item(KIND_HIT, 513);   // same bucket as t=1, retag
    push_item(KIND_QUERY, 513);
    push_item(KIND_HIT, 5);     // older timestamp, rejected
    push_item(KIND_QUERY, 2);
    push_item(KIND_HIT, 513);   // equal timestamp is fine
    push_item(KIND_QUERY, 600);
    push_item(KIND_QUERY, 812);
    push_item(KIND_QUERY, 813); // tag falls just out of the window
    push_item(KIND_QUERY, 812);
    stim_ts = 813;

    windows[0] = 0;
    windows[1] = '1;
    windows[2] = 1;
    windows[3] = WIN_W'(BUCKETS_DEF);
    windows[4] = WIN_W'(BUCKETS_DEF + 1);
    windows[5] = WIN_W'($urandom_range(2, 40));
    windows[6] = WIN_W'($urandom_range(514, 1022));
    windows[7] = WIN_RESET;
    for (int p = 0; p < 8; p++) begin
      write_window(windows[p]);
      if (p == 7) begin
        stim_ts = TS_MAX - 32'd400;
        run_random(75, TS_MAX);
      end else begin
        run_random(75, TS_CAP);
      end
    end

    push_item(KIND_HIT, TS_MAX);
    push_item(KIND_HIT, TS_MAX);
    push_item(KIND_QUERY, TS_MAX);
    push_item(KIND_QUERY, TS_MAX - 1);
    push_item(KIND_HIT, 1);

    drain_results();
    if (sb.errors == 0 && sb.pending_counts.size() == 0) begin
      $display("tb_sliding_window_hit_counter passed");
    end else begin
      $display("tb_sliding_window_hit_counter failed");
    end
    $finish;
  end

endmodule

// ----- sliding_window_hit_counter.f -----
sv/swhc_pkg.sv
sv/swhc_chan_if.sv
sv/swhc_mod.sv
sv/swhc_mem.sv
sv/sliding_window_hit_counter.sv
sim/tb_sliding_window_hit_counter.sv
